[src/eeprom_pkg.sv]
package eeprom_pkg;

    localparam int DATA_ADDR_BITS_DEF = 8;
    localparam int PROG_ADDR_BITS_DEF = 13;
    localparam int PROG_ADDR_MAX      = 16;

    localparam logic [7:0] KEY_FIRST  = 8'h55;
    localparam logic [7:0] KEY_SECOND = 8'hAA;
    localparam logic [7:0] KEY_NONE   = 8'h00;

    localparam int         PADDR_BITS       = 3;
    localparam logic       REG_PROG_ACCESS  = 1'b0;
    localparam logic       PROG_ACCESS_RST  = 1'b1;

    typedef enum logic [1:0] {
        STAGE_IDLE  = 2'd0,
        STAGE_FIRST = 2'd1,
        STAGE_ARMED = 2'd2
    } unlock_stage_t;

endpackage

[src/eeprom_unlock_rw_controller.sv]
// Unlock-protected read/write controller for a data EEPROM and a program memory.
// Input channel (in_valid/in_ready) carries one item per instruction cycle: the
// control bits, the key byte, the address and the data registers. Output channel
// (out_valid/out_ready) returns the registers after the step and a write_done flag.
// An item is captured in an input register, then one pass through the unlock logic
// and at most one memory access fill the result register. One item is taken per
// clock while the receiver does not stall and the sweep is over; a new item can
// enter the input register in the same cycle as the last one moves on.
// When the receiver stalls, the result register holds and the input register keeps
// its item; in_ready drops only in the sweep or while both are full and out_ready is low.
// Reset returns the unlock stage to idle and sets program_access_enable to 1. After
// reset both memories are swept to all ones, one address per clock, through all
// 2**PROG_ADDR_BITS program addresses (8192 by default); in_ready stays low during
// the sweep, while the APB port is served as usual.
// APB: program_access_enable at address 0 (bit 0); pready is always high.
module eeprom_unlock_rw_controller
    import eeprom_pkg::*;
#(
    parameter int DATA_ADDR_BITS = DATA_ADDR_BITS_DEF,
    parameter int PROG_ADDR_BITS = PROG_ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  program_space,
    input  logic                  write_enable,
    input  logic                  write_request,
    input  logic                  read_request,
    input  logic [7:0]            key_byte,
    input  logic [7:0]            addr_low,
    input  logic [4:0]            addr_high,
    input  logic [7:0]            data_low,
    input  logic [7:0]            data_high,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            data_low_out,
    output logic [7:0]            data_high_out,
    output logic                  read_request_after,
    output logic                  write_request_after,
    output logic [7:0]            key_byte_after,
    output logic                  write_done
);

    localparam int DATA_DEPTH = 1 << DATA_ADDR_BITS;
    localparam int PROG_DEPTH = 1 << PROG_ADDR_BITS;

    // configuration
    logic prog_access_reg;
    logic cfg_write;

    // sweep after reset
    logic                      clearing_reg;
    logic [PROG_ADDR_BITS-1:0] clr_addr_reg;

    // input register
    logic       s1_valid_reg;
    logic       ps_reg;
    logic       wren_reg;
    logic       wr_reg;
    logic       rd_reg;
    logic [7:0] key_reg;
    logic [7:0] alo_reg;
    logic [4:0] ahi_reg;
    logic [7:0] dlo_reg;
    logic [7:0] dhi_reg;

    // result register
    logic       out_valid_reg;
    logic       rd_done_reg;
    logic       rd_prog_reg;
    logic       wr_after_reg;
    logic [7:0] key_after_reg;
    logic       done_reg;
    logic [7:0] dlo_out_reg;
    logic [7:0] dhi_out_reg;
    logic [7:0] dmem_q_reg;
    logic [15:0] pmem_q_reg;

    unlock_stage_t stage_reg;
    unlock_stage_t stage_mid;
    unlock_stage_t stage_next;

    logic                      out_free;
    logic                      advance;
    logic                      key_hit;
    logic                      use_prog;
    logic                      do_write;
    logic [7:0]                key_next;
    logic [PROG_ADDR_MAX-1:0]  prog_addr_full;
    logic [PROG_ADDR_BITS-1:0] prog_addr;
    logic [DATA_ADDR_BITS-1:0] data_addr;

    logic                      pmem_we;
    logic [PROG_ADDR_BITS-1:0] pmem_waddr;
    logic [15:0]               pmem_wdata;
    logic                      dmem_we;
    logic [DATA_ADDR_BITS-1:0] dmem_waddr;
    logic [7:0]                dmem_wdata;

    logic [15:0] prog_mem [PROG_DEPTH];
    logic [7:0]  data_mem [DATA_DEPTH];

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PROG_ACCESS);
    assign prdata    = (paddr[2] == REG_PROG_ACCESS) ? {31'b0, prog_access_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_access_reg <= PROG_ACCESS_RST;
        end
        else if (cfg_write)
        begin
            prog_access_reg <= pwdata[0];
        end
    end

    // sweep both memories to the erased value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // flow control
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !clearing_reg && (!s1_valid_reg || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ps_reg   <= program_space;
            wren_reg <= write_enable;
            wr_reg   <= write_request;
            rd_reg   <= read_request;
            key_reg  <= key_byte;
            alo_reg  <= addr_low;
            ahi_reg  <= addr_high;
            dlo_reg  <= data_low;
            dhi_reg  <= data_high;
        end
    end

    // unlock rule, then the operation
    assign key_hit        = wren_reg && (key_reg != KEY_NONE);
    assign key_next       = key_hit ? KEY_NONE : key_reg;
    assign use_prog       = ps_reg && prog_access_reg;
    assign prog_addr_full = {3'b000, ahi_reg, alo_reg};
    assign prog_addr      = prog_addr_full[PROG_ADDR_BITS-1:0];
    assign data_addr      = alo_reg[DATA_ADDR_BITS-1:0];

    always_comb
    begin
        stage_mid = stage_reg;
        if (key_hit)
        begin
            if (key_reg == KEY_FIRST)
            begin
                stage_mid = STAGE_FIRST;
            end
            else if (key_reg == KEY_SECOND && stage_reg == STAGE_FIRST)
            begin
                stage_mid = STAGE_ARMED;
            end
            else
            begin
                stage_mid = STAGE_IDLE;
            end
        end
        do_write   = !rd_reg && wr_reg && (stage_mid == STAGE_ARMED);
        stage_next = do_write ? STAGE_IDLE : stage_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_IDLE;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    // memory write ports: sweep or armed write
    always_comb
    begin
        if (clearing_reg)
        begin
            pmem_we    = 1'b1;
            pmem_waddr = clr_addr_reg;
            pmem_wdata = '1;
            dmem_we    = 1'b1;
            dmem_waddr = clr_addr_reg[DATA_ADDR_BITS-1:0];
            dmem_wdata = '1;
        end
        else
        begin
            pmem_we    = advance && do_write && use_prog;
            pmem_waddr = prog_addr;
            pmem_wdata = {dhi_reg, dlo_reg};
            dmem_we    = advance && do_write && !use_prog;
            dmem_waddr = data_addr;
            dmem_wdata = dlo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pmem_we)
        begin
            prog_mem[pmem_waddr] <= pmem_wdata;
        end
        if (advance && rd_reg && use_prog)
        begin
            pmem_q_reg <= prog_mem[prog_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            data_mem[dmem_waddr] <= dmem_wdata;
        end
        if (advance && rd_reg && !use_prog)
        begin
            dmem_q_reg <= data_mem[data_addr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_done_reg   <= rd_reg;
            rd_prog_reg   <= use_prog;
            wr_after_reg  <= wr_reg && !do_write;
            key_after_reg <= key_next;
            done_reg      <= do_write;
            dlo_out_reg   <= dlo_reg;
            dhi_out_reg   <= dhi_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign data_low_out        = !rd_done_reg ? dlo_out_reg :
                                 (rd_prog_reg ? pmem_q_reg[7:0] : dmem_q_reg);
    assign data_high_out       = (rd_done_reg && rd_prog_reg) ? pmem_q_reg[15:8] : dhi_out_reg;
    // a pending read is always served, so the read bit always leaves clear
    assign read_request_after  = 1'b0;
    assign write_request_after = wr_after_reg;
    assign key_byte_after      = key_after_reg;
    assign write_done          = done_reg;

endmodule

[dv/eeprom_unlock_rw_controller_tb.sv]
module eeprom_unlock_rw_controller_tb;
    import eeprom_pkg::*;

    localparam int DATA_DEPTH = 1 << DATA_ADDR_BITS_DEF;
    localparam int PROG_DEPTH = 1 << PROG_ADDR_BITS_DEF;

    typedef struct {
        logic       prog_sel;
        logic       wren;
        logic       wr;
        logic       rd;
        logic [7:0] key;
        logic [7:0] alo;
        logic [4:0] ahi;
        logic [7:0] dlo;
        logic [7:0] dhi;
    } cycle_item_t;

    typedef struct {
        logic [7:0] dlo;
        logic [7:0] dhi;
        logic       rd;
        logic       wr;
        logic [7:0] key;
        logic       done;
    } regs_after_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    logic       in_valid;
    logic       in_ready;
    logic       program_space;
    logic       write_enable;
    logic       write_request;
    logic       read_request;
    logic [7:0] key_byte;
    logic [7:0] addr_low;
    logic [4:0] addr_high;
    logic [7:0] data_low;
    logic [7:0] data_high;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_low_out;
    logic [7:0] data_high_out;
    logic       read_request_after;
    logic       write_request_after;
    logic [7:0] key_byte_after;
    logic       write_done;

    // Shadow of the block's state
    logic          prog_access_en;
    unlock_stage_t stage;
    logic [7:0]    data_mem [DATA_DEPTH];
    logic [15:0]   prog_mem [PROG_DEPTH];

    regs_after_t regs_after_q [$];

    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;

    always #10 clk = ~clk;

    eeprom_unlock_rw_controller dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .program_space       (program_space),
        .write_enable        (write_enable),
        .write_request       (write_request),
        .read_request        (read_request),
        .key_byte            (key_byte),
        .addr_low            (addr_low),
        .addr_high           (addr_high),
        .data_low            (data_low),
        .data_high           (data_high),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .data_low_out        (data_low_out),
        .data_high_out       (data_high_out),
        .read_request_after  (read_request_after),
        .write_request_after (write_request_after),
        .key_byte_after      (key_byte_after),
        .write_done          (write_done)
    );

    function automatic void reset_shadow();
        prog_access_en = PROG_ACCESS_RST;
        stage = STAGE_IDLE;
        foreach (data_mem[i])
        begin
            data_mem[i] = '1;
        end
        foreach (prog_mem[i])
        begin
            prog_mem[i] = '1;
        end
    endfunction

    // One instruction cycle: unlock rule, then read or armed write
    function automatic regs_after_t eeprom_step(cycle_item_t it);
        regs_after_t                   r;
        logic                          use_prog;
        logic [DATA_ADDR_BITS_DEF-1:0] daddr;
        logic [PROG_ADDR_BITS_DEF-1:0] pgaddr;
        r.dlo = it.dlo;
        r.dhi = it.dhi;
        r.rd = it.rd;
        r.wr = it.wr;
        r.key = it.key;
        r.done = 1'b0;
        use_prog = it.prog_sel && prog_access_en;
        daddr = DATA_ADDR_BITS_DEF'(it.alo);
        pgaddr = PROG_ADDR_BITS_DEF'({it.ahi, it.alo});
        if (it.wren && it.key != KEY_NONE)
        begin
            if (it.key == KEY_FIRST)
                stage = STAGE_FIRST;
            else if (it.key == KEY_SECOND && stage == STAGE_FIRST)
                stage = STAGE_ARMED;
            else
                stage = STAGE_IDLE;
            r.key = KEY_NONE;
        end
        if (it.rd)
        begin
            if (use_prog)
                {r.dhi, r.dlo} = prog_mem[pgaddr];
            else
                r.dlo = data_mem[daddr];
            r.rd = 1'b0;
        end
        else if (it.wr && stage == STAGE_ARMED)
        begin
            if (use_prog)
                prog_mem[pgaddr] = {it.dhi, it.dlo};
            else
                data_mem[daddr] = it.dlo;
            r.wr = 1'b0;
            stage = STAGE_IDLE;
            r.done = 1'b1;
        end
        return r;
    endfunction

    function automatic cycle_item_t mk_item(logic prog, logic wren, logic wr, logic rd,
                                            logic [7:0] key, logic [7:0] alo,
                                            logic [4:0] ahi, logic [7:0] dlo,
                                            logic [7:0] dhi);
        cycle_item_t it;
        it.prog_sel = prog;
        it.wren = wren;
        it.wr = wr;
        it.rd = rd;
        it.key = key;
        it.alo = alo;
        it.ahi = ahi;
        it.dlo = dlo;
        it.dhi = dhi;
        return it;
    endfunction

    function automatic cycle_item_t rand_item();
        cycle_item_t it;
        it = mk_item(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 5'($urandom_range(31)),
                     8'($urandom_range(255)), 8'($urandom_range(255)));
        case ($urandom_range(3))
            0: it.key = KEY_FIRST;
            1: it.key = KEY_SECOND;
            2: it.key = KEY_NONE;
            default: ;
        endcase
        return it;
    endfunction

    // Keep most addresses in a small set so reads land on written words
    function automatic cycle_item_t hot_addr(cycle_item_t it);
        if ($urandom_range(3) != 0)
        begin
            it.alo = $urandom_range(1) ? 8'($urandom_range(7)) : 8'(248 + $urandom_range(7));
            it.ahi = $urandom_range(1) ? 5'd0 : 5'd31;
        end
        return it;
    endfunction

    task automatic send_item(cycle_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        program_space <= it.prog_sel;
        write_enable <= it.wren;
        write_request <= it.wr;
        read_request <= it.rd;
        key_byte <= it.key;
        addr_low <= it.alo;
        addr_high <= it.ahi;
        data_low <= it.dlo;
        data_high <= it.dhi;
        do
            @(posedge clk);
        while (!in_ready);
        regs_after_q.push_back(eeprom_step(it));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (regs_after_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_prog_access(logic en);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_BITS'(4 * int'(REG_PROG_ACCESS));
        pwdata <= {31'd0, en};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        prog_access_en = en;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_random(int n);
        cycle_item_t it;
        cycle_item_t wr_it;
        int          sent;
        int          pick;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                // unlock sequence followed by a write, sometimes a read back
                wr_it = hot_addr(rand_item());
                wr_it.rd = ($urandom_range(15) == 0);
                wr_it.wr = 1'b1;
                if ($urandom_range(3) != 0)
                    wr_it.key = KEY_NONE;
                it = rand_item();
                it.wren = ($urandom_range(15) != 0);
                it.key = KEY_FIRST;
                it.rd = ($urandom_range(9) == 0);
                send_item(it);
                it = hot_addr(rand_item());
                it.wren = ($urandom_range(15) != 0);
                it.key = KEY_SECOND;
                it.rd = ($urandom_range(9) == 0);
                it.wr = ($urandom_range(4) == 0);
                send_item(it);
                send_item(wr_it);
                sent += 3;
                if ($urandom_range(1))
                begin
                    it = wr_it;
                    it.rd = 1'b1;
                    it.wr = 1'b0;
                    it.key = KEY_NONE;
                    it.dlo = 8'($urandom_range(255));
                    it.dhi = 8'($urandom_range(255));
                    send_item(it);
                    sent++;
                end
            end
            else if (pick < 75)
            begin
                it = hot_addr(rand_item());
                it.rd = 1'b1;
                if ($urandom_range(4) != 0)
                    it.key = KEY_NONE;
                send_item(it);
                sent++;
            end
            else
            begin
                send_item(rand_item());
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        // erased memories read as all ones
        send_item(mk_item(0, 0, 0, 1, KEY_NONE, 8'h00, 5'd0, 8'h00, 8'h5A));
        send_item(mk_item(1, 0, 0, 1, KEY_NONE, 8'hFF, 5'd31, 8'h00, 8'h00));
        // write pending without unlock stays pending
        send_item(mk_item(0, 1, 1, 0, KEY_NONE, 8'h10, 5'd0, 8'h33, 8'h00));
        // key ignored while write enable is low
        send_item(mk_item(0, 0, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 0, 1, 0, KEY_SECOND, 8'h00, 5'd0, 8'h00, 8'h00));
        // normal unlock and data write, then read back
        send_item(mk_item(0, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 0, 0, KEY_SECOND, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 1, 0, KEY_NONE, 8'hFF, 5'd31, 8'h00, 8'hFF));
        send_item(mk_item(0, 0, 0, 1, KEY_NONE, 8'hFF, 5'd31, 8'hAB, 8'hCD));
        // armed program write with write enable already dropped
        send_item(mk_item(1, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(1, 1, 0, 0, KEY_SECOND, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(1, 0, 1, 0, KEY_NONE, 8'hFF, 5'd31, 8'h34, 8'h12));
        send_item(mk_item(1, 0, 0, 1, KEY_NONE, 8'hFF, 5'd31, 8'h00, 8'h00));
        // read and write both pending: read wins, stage stays armed
        send_item(mk_item(1, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(1, 1, 1, 1, KEY_SECOND, 8'hFF, 5'd31, 8'h00, 8'h00));
        send_item(mk_item(1, 0, 1, 0, KEY_NONE, 8'h00, 5'd0, 8'hFF, 8'hFF));
        // stray key returns to idle, lone second key does not arm
        send_item(mk_item(0, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 0, 0, 8'h12, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 1, 0, KEY_SECOND, 8'h01, 5'd0, 8'h77, 8'h00));
        // repeated first key then second key arms
        send_item(mk_item(0, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 1, 0, KEY_SECOND, 8'h80, 5'd4, 8'h03, 8'h80));
        send_item(mk_item(0, 1, 0, 1, 8'hFF, 8'h80, 5'd4, 8'h00, 8'h00));
        wait_all_results();
    endtask

    task automatic test_program_access_off();
        write_prog_access(1'b0);
        send_idle_pct = 0;
        stall_pct = 0;
        // program space select is ignored: both go to data EEPROM
        send_item(mk_item(1, 1, 0, 0, KEY_FIRST, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(1, 1, 0, 0, KEY_SECOND, 8'h00, 5'd0, 8'h00, 8'h00));
        send_item(mk_item(1, 1, 1, 0, KEY_NONE, 8'h10, 5'd3, 8'h77, 8'h88));
        send_item(mk_item(1, 0, 0, 1, KEY_NONE, 8'h10, 5'd3, 8'h00, 8'h99));
        run_random(100);
        wait_all_results();
    endtask

    task automatic test_random_phases();
        int   idle_tbl [4] = '{0, 62, 0, 8};
        int   stall_tbl [4] = '{0, 0, 62, 8};
        logic cfg_tbl [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
        for (int p = 0; p < 4; p++)
        begin
            write_prog_access(cfg_tbl[p]);
            send_idle_pct = idle_tbl[p];
            stall_pct = stall_tbl[p];
            run_random(220);
            wait_all_results();
        end
    endtask

    task automatic test_backpressure();
        write_prog_access(1'b1);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 60;
        run_random(30);
        wait_all_results();
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        regs_after_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (regs_after_q.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
            end
            else
            begin
                want = regs_after_q.pop_front();
                if (data_low_out !== want.dlo)
                begin
                    $error("data_low_out: expected %h, got %h", want.dlo, data_low_out);
                    errors++;
                end
                if (data_high_out !== want.dhi)
                begin
                    $error("data_high_out: expected %h, got %h", want.dhi, data_high_out);
                    errors++;
                end
                if (read_request_after !== want.rd)
                begin
                    $error("read_request_after: expected %b, got %b",
                           want.rd, read_request_after);
                    errors++;
                end
                if (write_request_after !== want.wr)
                begin
                    $error("write_request_after: expected %b, got %b",
                           want.wr, write_request_after);
                    errors++;
                end
                if (key_byte_after !== want.key)
                begin
                    $error("key_byte_after: expected %h, got %h", want.key, key_byte_after);
                    errors++;
                end
                if (write_done !== want.done)
                begin
                    $error("write_done: expected %b, got %b", want.done, write_done);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        program_space = 1'b0;
        write_enable = 1'b0;
        write_request = 1'b0;
        read_request = 1'b0;
        key_byte = '0;
        addr_low = '0;
        addr_high = '0;
        data_low = '0;
        data_high = '0;
        reset_shadow();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_program_access_off();
        test_random_phases();
        test_backpressure();

        wait_all_results();
        if (errors == 0)
            $display("eeprom_unlock_rw_controller_tb: PASS");
        else
            $display("eeprom_unlock_rw_controller_tb: FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("eeprom_unlock_rw_controller_tb: FAIL");
        $finish;
    end

endmodule
